FILE: hdl/blesp_pkg.sv
// ----------------------------------------------------------------------------
// BLE sensor parser package
// Shared types and constants for the advertising-data structure parser.
// ----------------------------------------------------------------------------
package blesp_pkg;

    localparam int MAX_REPORT_BYTES = 31;

    localparam logic [7:0]  TYPE_NAME_SHORT    = 8'h08;
    localparam logic [7:0]  TYPE_NAME_COMPLETE = 8'h09;
    localparam logic [7:0]  TYPE_MANUFACTURER  = 8'hFF;
    localparam logic [7:0]  SENSOR_LEN_A       = 8'd9;
    localparam logic [7:0]  SENSOR_LEN_B       = 8'd10;
    localparam logic [15:0] MATCH_RESET        = 16'h88EC;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Reciprocal of 1000 scaled by 2^34, exact for 24-bit dividends
    localparam int          DIV_SHIFT = 34;
    localparam int          QUOT_W    = 15;
    localparam logic [24:0] DIV_RECIP = 25'd17179870;

    localparam logic [20:0] TEMP_OFFSET = 21'd16000;

    typedef enum logic [1:0] {
        KIND_NAME_BYTE  = 2'd0,
        KIND_NAME_EMPTY = 2'd1,
        KIND_SENSOR     = 2'd2,
        KIND_LEN_ERROR  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [47:0] addr;
        logic [7:0]  name_char;
        logic        name_last;
        logic        len10;
        logic [7:0]  p3;
        logic [7:0]  p4;
        logic [7:0]  p5;
        logic [7:0]  p6;
        logic [7:0]  p7;
    } cmd_t;

endpackage

FILE: hdl/blesp_front.sv
// ----------------------------------------------------------------------------
// BLE sensor parser front end
// Walks the length/type/payload structures and issues one command per result.
// ----------------------------------------------------------------------------
module blesp_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [7:0]        data_byte,
    input  logic              report_start,
    input  logic [4:0]        report_length,
    input  logic [47:0]       device_address,
    input  logic [15:0]       match,
    output logic              push,
    output blesp_pkg::cmd_t   cmd
);

    logic [7:0] pos_reg, pos_next;
    logic [7:0] rem_reg, rem_next;
    logic [7:0] slen_reg, slen_next;
    logic [7:0] stype_reg, stype_next;
    logic       halt_reg, halt_next;
    logic [7:0] store_reg [8];
    logic       store_we;
    logic [2:0] store_addr;

    always_comb
    begin
        logic [7:0] pos_b;
        logic [7:0] rem_b;
        logic [7:0] slen_b;
        logic [7:0] stype_b;
        logic       halt_b;
        logic [7:0] len_eff;
        logic       report_end;
        logic [7:0] idx;
        logic [7:0] rem_new;
        logic [7:0] p;
        logic       is_name;

        pos_next   = pos_reg;
        rem_next   = rem_reg;
        slen_next  = slen_reg;
        stype_next = stype_reg;
        halt_next  = halt_reg;
        store_we   = 1'b0;
        store_addr = '0;
        push       = 1'b0;
        cmd        = '0;
        cmd.addr   = device_address;
        cmd.p3     = store_reg[3];
        cmd.p4     = store_reg[4];
        cmd.p5     = store_reg[5];
        cmd.p6     = store_reg[6];
        cmd.p7     = store_reg[7];
        cmd.len10  = (slen_reg == blesp_pkg::SENSOR_LEN_B);

        pos_b   = report_start ? 8'd0 : pos_reg;
        rem_b   = report_start ? 8'd0 : rem_reg;
        slen_b  = report_start ? 8'd0 : slen_reg;
        stype_b = report_start ? 8'd0 : stype_reg;
        halt_b  = report_start ? 1'b0 : halt_reg;

        len_eff = (8'(report_length) > 8'(blesp_pkg::MAX_REPORT_BYTES))
                  ? 8'(blesp_pkg::MAX_REPORT_BYTES) : 8'(report_length);
        report_end = ((9'(pos_b) + 9'd1) == 9'(len_eff));
        idx     = slen_b - rem_b;
        rem_new = rem_b - 8'd1;
        p       = idx - 8'd1;
        is_name = (stype_b == blesp_pkg::TYPE_NAME_SHORT) ||
                  (stype_b == blesp_pkg::TYPE_NAME_COMPLETE);

        if (take)
        begin
            pos_next   = pos_b;
            rem_next   = rem_b;
            slen_next  = slen_b;
            stype_next = stype_b;
            halt_next  = halt_b;

            if (!halt_b && (pos_b < len_eff))
            begin
                if (pos_b != 8'hFF)
                begin
                    pos_next = pos_b + 8'd1;
                end

                if (rem_b == 8'd0)
                begin
                    if ((9'(data_byte) + 9'd1) > 9'(len_eff))
                    begin
                        halt_next = 1'b1;
                        push      = 1'b1;
                        cmd.kind  = blesp_pkg::KIND_LEN_ERROR;
                    end
                    else if (data_byte != 8'd0)
                    begin
                        slen_next = data_byte;
                        rem_next  = data_byte;
                    end
                end
                else
                begin
                    rem_next = rem_new;
                    if (idx == 8'd0)
                    begin
                        stype_next = data_byte;
                        if (((data_byte == blesp_pkg::TYPE_NAME_SHORT) ||
                             (data_byte == blesp_pkg::TYPE_NAME_COMPLETE)) &&
                            (rem_new == 8'd0))
                        begin
                            push     = 1'b1;
                            cmd.kind = blesp_pkg::KIND_NAME_EMPTY;
                        end
                    end
                    else if (is_name)
                    begin
                        push          = 1'b1;
                        cmd.kind      = blesp_pkg::KIND_NAME_BYTE;
                        cmd.name_char = data_byte;
                        cmd.name_last = (rem_new == 8'd0) || report_end;
                    end
                    else if (stype_b == blesp_pkg::TYPE_MANUFACTURER)
                    begin
                        if (p < 8'd8)
                        begin
                            store_we   = 1'b1;
                            store_addr = p[2:0];
                        end
                        if ((rem_new == 8'd0) &&
                            ((slen_b == blesp_pkg::SENSOR_LEN_A) ||
                             (slen_b == blesp_pkg::SENSOR_LEN_B)) &&
                            (store_reg[0] == match[15:8]) &&
                            (store_reg[1] == match[7:0]))
                        begin
                            push     = 1'b1;
                            cmd.kind = blesp_pkg::KIND_SENSOR;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            rem_reg   <= '0;
            slen_reg  <= '0;
            stype_reg <= '0;
            halt_reg  <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            rem_reg   <= rem_next;
            slen_reg  <= slen_next;
            stype_reg <= stype_next;
            halt_reg  <= halt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[store_addr] <= data_byte;
        end
    end

endmodule

FILE: hdl/blesp_queue.sv
// ----------------------------------------------------------------------------
// BLE sensor parser command queue
// Short FIFO between the parsing front end and the decoding back end.
// ----------------------------------------------------------------------------
module blesp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  blesp_pkg::cmd_t   push_cmd,
    input  logic              pop,
    output logic              head_valid,
    output blesp_pkg::cmd_t   head_cmd,
    output logic              full
);

    blesp_pkg::cmd_t                     mem_reg [blesp_pkg::QUEUE_DEPTH];
    logic [blesp_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [blesp_pkg::QUEUE_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [blesp_pkg::QUEUE_CNT_W-1:0]   count_reg, count_next;
    logic                                do_push;
    logic                                do_pop;

    always_comb
    begin
        full        = (count_reg == blesp_pkg::QUEUE_CNT_W'(blesp_pkg::QUEUE_DEPTH));
        head_valid  = (count_reg != '0);
        head_cmd    = mem_reg[rd_ptr_reg];
        do_push     = push && !full;
        do_pop      = pop && head_valid;
        wr_ptr_next = do_push ? wr_ptr_reg + blesp_pkg::QUEUE_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + blesp_pkg::QUEUE_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + blesp_pkg::QUEUE_CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - blesp_pkg::QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: hdl/blesp_back.sv
// ----------------------------------------------------------------------------
// BLE sensor parser back end
// Decodes sensor readings in two stages and holds the result word.
// ----------------------------------------------------------------------------
module blesp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  blesp_pkg::cmd_t   head_cmd,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        result_kind,
    output logic [47:0]       sender_address,
    output logic [7:0]        name_char,
    output logic              name_last,
    output logic [20:0]       temperature,
    output logic [15:0]       humidity,
    output logic [7:0]        battery
);

    logic                               advance;
    logic [23:0]                        dividend;
    logic [48:0]                        product;
    logic                               s1_valid_reg;
    blesp_pkg::cmd_t                    s1_cmd_reg;
    logic [blesp_pkg::QUOT_W-1:0]       s1_quot_reg;
    logic                               out_valid_reg;
    logic [1:0]                         kind_reg,  kind_next;
    logic [47:0]                        addr_reg,  addr_next;
    logic [7:0]                         char_reg,  char_next;
    logic                               last_reg,  last_next;
    logic [20:0]                        temp_reg,  temp_next;
    logic [15:0]                        hum_reg,   hum_next;
    logic [7:0]                         bat_reg,   bat_next;

    always_comb
    begin
        advance  = !out_valid_reg || !out_stall;
        pop      = head_valid && advance;
        dividend = {head_cmd.p3, head_cmd.p4, head_cmd.p5};
        product  = 49'(dividend) * 49'(blesp_pkg::DIV_RECIP);
    end

    always_comb
    begin
        logic [23:0] v;
        logic [27:0] hum_wide;

        v         = {s1_cmd_reg.p3, s1_cmd_reg.p4, s1_cmd_reg.p5};
        hum_wide  = 28'(v) * 28'd10 - 28'(s1_quot_reg) * 28'd10000;
        kind_next = s1_cmd_reg.kind;
        addr_next = s1_cmd_reg.addr;
        char_next = '0;
        last_next = 1'b0;
        temp_next = '0;
        hum_next  = '0;
        bat_next  = '0;
        unique case (s1_cmd_reg.kind) inside
            blesp_pkg::KIND_NAME_BYTE:
            begin
                char_next = s1_cmd_reg.name_char;
                last_next = s1_cmd_reg.name_last;
            end
            blesp_pkg::KIND_SENSOR:
            begin
                if (s1_cmd_reg.len10)
                begin
                    temp_next = 21'({s1_cmd_reg.p4, s1_cmd_reg.p3}) * 21'd9
                                + blesp_pkg::TEMP_OFFSET;
                    hum_next  = {s1_cmd_reg.p6, s1_cmd_reg.p5};
                    bat_next  = s1_cmd_reg.p7;
                end
                else
                begin
                    temp_next = 21'(s1_quot_reg) * 21'd90 + blesp_pkg::TEMP_OFFSET;
                    hum_next  = hum_wide[15:0];
                    bat_next  = s1_cmd_reg.p6;
                end
            end
            blesp_pkg::KIND_NAME_EMPTY,
            blesp_pkg::KIND_LEN_ERROR:
            begin
                char_next = '0;
            end
            default:
            begin
                char_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= pop;
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_cmd_reg  <= head_cmd;
            s1_quot_reg <= product[blesp_pkg::DIV_SHIFT +: blesp_pkg::QUOT_W];
            kind_reg    <= kind_next;
            addr_reg    <= addr_next;
            char_reg    <= char_next;
            last_reg    <= last_next;
            temp_reg    <= temp_next;
            hum_reg     <= hum_next;
            bat_reg     <= bat_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_kind    = kind_reg;
    assign sender_address = addr_reg;
    assign name_char      = char_reg;
    assign name_last      = last_reg;
    assign temperature    = temp_reg;
    assign humidity       = hum_reg;
    assign battery        = bat_reg;

endmodule

FILE: hdl/ble_adv_sensor_reading_parser.sv
// ----------------------------------------------------------------------------
// BLE advertising sensor reading parser
// Feed the advertising-data bytes of each report on the input channel, one
// word per byte, with report_start high on the first byte. Results leave on
// the output channel: name bytes, empty-name marks, decoded sensor readings
// and length errors, each tagged with the sender address.
// Throughput: one byte per cycle while in_stall is low; the front end parses
// each byte as it is taken, and the back end decoder takes one word per
// cycle while its output is not stalled. A result word goes through the
// queue write, divider stage and output register, then shows on out_valid.
// A four-word queue sits between parser and decoder; in_stall rises only
// when that queue is full, which happens while out_stall holds the output.
// A stalled result word holds its value until taken.
// Reset clears the parse state, the queue and the pipeline valids and loads
// match_reg with 0x88EC. cfg_ready is always high; write the match
// register only while no bytes are in flight.
// ----------------------------------------------------------------------------
module ble_adv_sensor_reading_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        report_start,
    input  logic [4:0]  report_length,
    input  logic [47:0] device_address,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_kind,
    output logic [47:0] sender_address,
    output logic [7:0]  name_char,
    output logic        name_last,
    output logic [20:0] temperature,
    output logic [15:0] humidity,
    output logic [7:0]  battery
);

    logic [15:0]       match_reg;
    logic              take;
    logic              push;
    blesp_pkg::cmd_t   push_cmd;
    logic              pop;
    logic              head_valid;
    blesp_pkg::cmd_t   head_cmd;
    logic              full;

    assign cfg_ready = 1'b1;
    assign in_stall  = full;
    assign take      = in_valid && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= blesp_pkg::MATCH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            match_reg <= cfg_data;
        end
    end

    blesp_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .take           (take),
        .data_byte      (data_byte),
        .report_start   (report_start),
        .report_length  (report_length),
        .device_address (device_address),
        .match          (match_reg),
        .push           (push),
        .cmd            (push_cmd)
    );

    blesp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .full       (full)
    );

    blesp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (head_valid),
        .head_cmd       (head_cmd),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_kind    (result_kind),
        .sender_address (sender_address),
        .name_char      (name_char),
        .name_last      (name_last),
        .temperature    (temperature),
        .humidity       (humidity),
        .battery        (battery)
    );

endmodule

FILE: hdl/blesp_checker.sv
// ----------------------------------------------------------------------------
// BLE sensor parser port checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module blesp_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  result_kind,
    input  logic [47:0] sender_address,
    input  logic [7:0]  name_char,
    input  logic        name_last,
    input  logic [20:0] temperature,
    input  logic [15:0] humidity,
    input  logic [7:0]  battery
);

    a_name_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (result_kind != blesp_pkg::KIND_NAME_BYTE))
        |-> (name_char == 8'd0) && !name_last)
        else $error("name fields set on a non-name word");

    a_sensor_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (result_kind != blesp_pkg::KIND_SENSOR))
        |-> (temperature == 21'd0) && (humidity == 16'd0) && (battery == 8'd0))
        else $error("sensor fields set on a non-sensor word");

    a_sensor_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (result_kind == blesp_pkg::KIND_SENSOR))
        |-> (temperature >= blesp_pkg::TEMP_OFFSET))
        else $error("sensor temperature below offset");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall)
        |=> out_valid && $stable(result_kind) && $stable(sender_address)
            && $stable(temperature))
        else $error("stalled result word changed");

endmodule

bind ble_adv_sensor_reading_parser blesp_checker u_blesp_checker (.*);
